@@ hdl/sla_pkg.sv @@
package sla_pkg;

  localparam int MAX_SETS_DEF = 256;
  localparam int MAX_WAYS_DEF = 8;

  localparam int ADDR_W     = 64;
  localparam int TAG_W      = 64;
  localparam int STAMP_W    = 64;
  localparam int CNT_W      = 32;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SETB_W     = 4;
  localparam int BLKB_W     = 6;
  localparam int WAYS_W     = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MODIFY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS       = 2'd2;

  localparam logic [SETB_W-1:0] SET_BITS_RST   = 4'd4;
  localparam logic [BLKB_W-1:0] BLOCK_BITS_RST = 6'd4;
  localparam logic [WAYS_W-1:0] WAYS_RST       = 4'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_COMMIT
  } sla_state_t;

  typedef struct packed {
    logic clear_step;
    logic load;
    logic scan_start;
    logic scan_step;
    logic commit;
  } sla_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic scan_needed;
    logic scan_last;
  } sla_stat_t;

endpackage

@@ hdl/sla_in_if.sv @@
interface sla_in_if import sla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;

  modport source (output valid, kind, address, input ready);
  modport sink   (input valid, kind, address, output ready);
endinterface

@@ hdl/sla_out_if.sv @@
interface sla_out_if import sla_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             was_hit;
  logic             was_miss;
  logic             was_eviction;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] eviction_total;

  modport source (output valid, was_hit, was_miss, was_eviction, hit_total, miss_total,
                  eviction_total, input ready);
  modport sink   (input valid, was_hit, was_miss, was_eviction, hit_total, miss_total,
                  eviction_total, output ready);
endinterface

@@ hdl/sla_cfg_if.sv @@
interface sla_cfg_if import sla_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/sla_ctrl.sv @@
module sla_ctrl import sla_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  sla_stat_t stat,
  output sla_cmd_t  cmd
);

  sla_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat.scan_needed) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase

    // A new result replaces a taken one in the same cycle.
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

endmodule

@@ hdl/sla_dp.sv @@
module sla_dp import sla_pkg::*; #(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sla_cmd_t              cmd,
  output sla_stat_t             stat,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [ADDR_W-1:0]     in_address,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_was_hit,
  output logic                  out_was_miss,
  output logic                  out_was_eviction,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total,
  output logic [CNT_W-1:0]      out_eviction_total
);

  localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int S_MAX     = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int TAG_OFS   = MAX_WAYS;
  localparam int STAMP_OFS = MAX_WAYS * (1 + TAG_W);
  localparam int ROW_W     = MAX_WAYS * (1 + TAG_W + STAMP_W);

  // Configuration registers.
  logic [SETB_W-1:0] setb_r;
  logic [BLKB_W-1:0] blkb_r;
  logic [WAYS_W-1:0] ways_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setb_r <= SET_BITS_RST;
      blkb_r <= BLOCK_BITS_RST;
      ways_r <= WAYS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SET_BITS:   setb_r <= cfg_data[SETB_W-1:0];
        REG_BLOCK_BITS: blkb_r <= cfg_data[BLKB_W-1:0];
        REG_WAYS:       ways_r <= cfg_data[WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SETB_W-1:0] eff_s;
  logic [WCNT_W-1:0] eff_w;

  assign eff_s = (int'(setb_r) > S_MAX) ? SETB_W'(S_MAX) : setb_r;

  always_comb begin
    if (ways_r == '0)                  eff_w = WCNT_W'(1);
    else if (int'(ways_r) > MAX_WAYS)  eff_w = WCNT_W'(MAX_WAYS);
    else                               eff_w = WCNT_W'(ways_r);
  end

  // Address split for the incoming request.
  logic [ADDR_W-1:0] shifted_in;
  logic [SET_AW-1:0] set_mask;
  logic [SET_AW-1:0] set_in;
  logic [6:0]        tag_shift;
  logic [TAG_W-1:0]  tag_in;

  assign shifted_in = in_address >> blkb_r;
  assign set_mask   = SET_AW'((32'd1 << eff_s) - 32'd1);
  assign set_in     = shifted_in[SET_AW-1:0] & set_mask;
  assign tag_shift  = 7'(blkb_r) + 7'(eff_s);
  assign tag_in     = (tag_shift >= 7'd64) ? '0 : (in_address >> tag_shift);

  // Request registers.
  logic [KIND_W-1:0] kind_r;
  logic [SET_AW-1:0] set_r;
  logic [TAG_W-1:0]  tag_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      set_r  <= set_in;
      tag_r  <= tag_in;
    end
  end

  // Set memory: one row holds valid bits, tags and stamps of all ways.
  logic [ROW_W-1:0]  mem [MAX_SETS];
  logic [ROW_W-1:0]  rd_row_r;
  logic [ROW_W-1:0]  new_row;
  logic [SET_AW-1:0] clr_addr_r;
  logic              row_we;

  always_ff @(posedge clk) begin
    if (cmd.clear_step)  mem[clr_addr_r] <= '0;
    else if (row_we)     mem[set_r] <= new_row;
    if (cmd.load) rd_row_r <= mem[set_in];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)              clr_addr_r <= '0;
    else if (cmd.clear_step) clr_addr_r <= clr_addr_r + 1'b1;
  end

  // Lookup over the ways of the row.
  logic [MAX_WAYS-1:0] hit_vec;
  logic [MAX_WAYS-1:0] inv_vec;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    inv_way;
  logic                is_hit;
  logic                has_inv;
  logic                is_ign;
  logic                is_mod;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      hit_vec[i] = (WCNT_W'(i) < eff_w) && rd_row_r[i] &&
                   (rd_row_r[TAG_OFS + i*TAG_W +: TAG_W] == tag_r);
      inv_vec[i] = (WCNT_W'(i) < eff_w) && !rd_row_r[i];
    end
    // Walk downward so the lowest matching index wins.
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_way = WAY_W'(i);
      if (inv_vec[i]) inv_way = WAY_W'(i);
    end
  end

  assign is_hit  = |hit_vec;
  assign has_inv = |inv_vec;
  assign is_ign  = (kind_r == KIND_IGNORE);
  assign is_mod  = (kind_r == KIND_MODIFY);

  // Oldest-stamp search, one way per cycle.
  logic [WAY_W-1:0]   idx_r;
  logic [WAY_W-1:0]   best_r;
  logic [STAMP_W-1:0] best_stamp_r;
  logic [STAMP_W-1:0] idx_stamp;

  assign idx_stamp = rd_row_r[STAMP_OFS + int'(idx_r)*STAMP_W +: STAMP_W];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      best_r <= '0;
    end else if (cmd.scan_start) begin
      best_r       <= '0;
      best_stamp_r <= rd_row_r[STAMP_OFS +: STAMP_W];
      idx_r        <= WAY_W'(1);
    end else if (cmd.scan_step) begin
      if (idx_stamp < best_stamp_r) begin
        best_r       <= idx_r;
        best_stamp_r <= idx_stamp;
      end
      idx_r <= idx_r + 1'b1;
    end
  end

  assign stat.clear_last  = (clr_addr_r == SET_AW'(MAX_SETS - 1));
  assign stat.scan_needed = !is_ign && !is_hit && !has_inv && (eff_w > WCNT_W'(1));
  assign stat.scan_last   = (WCNT_W'(idx_r) == (eff_w - WCNT_W'(1)));

  // Commit: row update, counters and the result register.
  logic [WAY_W-1:0]   victim;
  logic [STAMP_W-1:0] stamp_r, stamp_nxt, stamp_new;
  logic [CNT_W-1:0]   hits_r, hits_nxt;
  logic [CNT_W-1:0]   misses_r, misses_nxt;
  logic [CNT_W-1:0]   evicts_r, evicts_nxt;
  logic               evict;

  assign victim = is_hit ? hit_way : (has_inv ? inv_way : best_r);
  assign evict  = !is_hit && !has_inv;
  assign row_we = cmd.commit && !is_ign;

  // The second lookup of a modify always hits the same way, so both lookups
  // fold into one write whose stamp is one past the first.
  assign stamp_new = stamp_r + STAMP_W'(is_mod);

  always_comb begin
    new_row = rd_row_r;
    new_row[victim] = 1'b1;
    new_row[TAG_OFS + int'(victim)*TAG_W +: TAG_W]       = tag_r;
    new_row[STAMP_OFS + int'(victim)*STAMP_W +: STAMP_W] = stamp_new;

    stamp_nxt  = stamp_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    evicts_nxt = evicts_r;
    if (!is_ign) begin
      stamp_nxt  = stamp_r + STAMP_W'(1) + STAMP_W'(is_mod);
      hits_nxt   = hits_r + CNT_W'(is_hit) + CNT_W'(is_mod);
      misses_nxt = misses_r + CNT_W'(!is_hit);
      evicts_nxt = evicts_r + CNT_W'(evict);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_r  <= '0;
      hits_r   <= '0;
      misses_r <= '0;
      evicts_r <= '0;
    end else if (cmd.commit) begin
      stamp_r  <= stamp_nxt;
      hits_r   <= hits_nxt;
      misses_r <= misses_nxt;
      evicts_r <= evicts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_was_hit        <= !is_ign && (is_hit || is_mod);
      out_was_miss       <= !is_ign && !is_hit;
      out_was_eviction   <= !is_ign && evict;
      out_hit_total      <= hits_nxt;
      out_miss_total     <= misses_nxt;
      out_eviction_total <= evicts_nxt;
    end
  end

endmodule

@@ hdl/set_assoc_lru_cache_tags_top.sv @@
// Tag store of a set-associative cache with least-recently-used replacement.
// Requests arrive on in_ch (kind, address) and each produces exactly one result
// on out_ch: hit, miss and eviction flags of the request plus running totals.
// cfg_ch writes set_bits (index 0), block_bits (1) and ways_in_use (2); it is
// always ready and should only be used while no request is in flight.
// A request is taken in one cycle and evaluated against the set row read from
// memory in the next; its result is then written to the output register.
// Hits, fills of an invalid way, ignored kinds and misses with a single way in
// use need no search. A miss in a full set with more ways walks the ways one
// per cycle looking for the oldest stamp, over the effective number of ways
// (ways_in_use held to 1..MAX_WAYS). A modify costs the same as a load, since
// its second lookup is folded into the same row write.
// After reset the set memory is cleared one row per cycle, over all MAX_SETS
// rows, with in_ch.ready low; configuration writes are accepted meanwhile.
// The result sits in an output register, so the next request is accepted
// while it waits. If out_ch stalls, the following result is held until the
// register frees up, and no further request is accepted until then.
module set_assoc_lru_cache_tags_top import sla_pkg::*; #(
  parameter int MAX_SETS = MAX_SETS_DEF,
  parameter int MAX_WAYS = MAX_WAYS_DEF
) (
  input logic   clk,
  input logic   rst_n,
  sla_in_if.sink    in_ch,
  sla_out_if.source out_ch,
  sla_cfg_if.sink   cfg_ch
);

  sla_cmd_t  cmd;
  sla_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  sla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sla_dp #(
    .MAX_SETS (MAX_SETS),
    .MAX_WAYS (MAX_WAYS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_kind            (in_ch.kind),
    .in_address         (in_ch.address),
    .cfg_we             (cfg_ch.valid),
    .cfg_index          (cfg_ch.index),
    .cfg_data           (cfg_ch.data),
    .out_was_hit        (out_ch.was_hit),
    .out_was_miss       (out_ch.was_miss),
    .out_was_eviction   (out_ch.was_eviction),
    .out_hit_total      (out_ch.hit_total),
    .out_miss_total     (out_ch.miss_total),
    .out_eviction_total (out_ch.eviction_total)
  );

  // Only one request is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // A stalled result must never be overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !cmd.commit)
    else $error("result register overwritten while stalled");

  // No request is taken while the memory is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_step |-> !in_ch.ready)
    else $error("request accepted during clearing pass");

  // A commit always raises the result valid on the next cycle.
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_ch.valid)
    else $error("commit did not produce a result");

endmodule

@@ test/tb_top.sv @@
module tb_top import sla_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES         = MAX_SETS_DEF * MAX_WAYS_DEF;
  localparam int SET_BITS_CAP  = $clog2(MAX_SETS_DEF);
  localparam int DRAIN_CYCLES  = MAX_WAYS_DEF + 8;
  localparam int PHASE_ITEMS   = 70;
  localparam int PRESSURE_HOLD = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic             hit;
    logic             miss;
    logic             evict;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_result_t;

  logic clk;
  logic rst_n;

  sla_in_if  in_bus ();
  sla_out_if out_bus ();
  sla_cfg_if cfg_bus ();

  set_assoc_lru_cache_tags_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // Shadow copy of the tag store and its configuration.
  logic               shadow_valid [LINES];
  logic [TAG_W-1:0]   shadow_tag   [LINES];
  logic [STAMP_W-1:0] shadow_stamp [LINES];
  logic [STAMP_W-1:0] lru_clock;
  logic [CNT_W-1:0]   hit_count;
  logic [CNT_W-1:0]   miss_count;
  logic [CNT_W-1:0]   evict_count;
  logic [SETB_W-1:0]  cfg_set_bits;
  logic [BLKB_W-1:0]  cfg_block_bits;
  logic [WAYS_W-1:0]  cfg_ways;

  access_result_t   pending_results [$];
  logic [TAG_W-1:0] tag_pool [$];
  int               error_count;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               hold_request;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int effective_set_bits();
    return (cfg_set_bits > SET_BITS_CAP) ? SET_BITS_CAP : int'(cfg_set_bits);
  endfunction

  function automatic int effective_ways();
    if (cfg_ways == 0) return 1;
    if (cfg_ways > MAX_WAYS_DEF) return MAX_WAYS_DEF;
    return int'(cfg_ways);
  endfunction

  function automatic void lookup_line(input logic [ADDR_W-1:0] addr, output logic hit,
                                      output logic evict);
    int s;
    int w;
    int shift;
    int base;
    int victim;
    logic [ADDR_W-1:0] set_idx;
    logic [TAG_W-1:0]  tag;
    s = effective_set_bits();
    w = effective_ways();
    shift = int'(cfg_block_bits) + s;
    set_idx = (addr >> cfg_block_bits) & ((64'd1 << s) - 64'd1);
    tag = (shift >= ADDR_W) ? '0 : (addr >> shift);
    base = int'(set_idx) * MAX_WAYS_DEF;
    hit = 1'b0;
    evict = 1'b0;
    for (int i = 0; i < w; i++) begin
      if (shadow_valid[base + i] && shadow_tag[base + i] == tag) begin
        shadow_stamp[base + i] = lru_clock;
        lru_clock++;
        hit_count++;
        hit = 1'b1;
        return;
      end
    end
    miss_count++;
    // Invalid ways are filled first, lowest index first.
    victim = -1;
    for (int i = 0; i < w && victim < 0; i++) begin
      if (!shadow_valid[base + i]) victim = i;
    end
    if (victim < 0) begin
      victim = 0;
      for (int i = 1; i < w; i++) begin
        if (shadow_stamp[base + i] < shadow_stamp[base + victim]) victim = i;
      end
      evict = 1'b1;
      evict_count++;
    end
    shadow_valid[base + victim] = 1'b1;
    shadow_tag[base + victim]   = tag;
    shadow_stamp[base + victim] = lru_clock;
    lru_clock++;
  endfunction

  function automatic access_result_t predict_access(input logic [KIND_W-1:0] kind,
                                                    input logic [ADDR_W-1:0] addr);
    access_result_t r;
    logic hit;
    logic evict;
    int   lookups;
    r = '0;
    lookups = (kind == KIND_MODIFY) ? 2 : ((kind == KIND_IGNORE) ? 0 : 1);
    for (int i = 0; i < lookups; i++) begin
      lookup_line(addr, hit, evict);
      r.hit   |= hit;
      r.miss  |= !hit;
      r.evict |= evict;
    end
    r.hits      = hit_count;
    r.misses    = miss_count;
    r.evictions = evict_count;
    return r;
  endfunction

  function automatic void refresh_tag_pool();
    tag_pool.delete();
    for (int i = 0; i < effective_ways() + 3; i++) tag_pool.push_back({$urandom, $urandom});
  endfunction

  function automatic logic [KIND_W-1:0] random_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return KIND_LOAD;
    if (r < 65) return KIND_STORE;
    if (r < 92) return KIND_MODIFY;
    return KIND_IGNORE;
  endfunction

  // Addresses mostly reuse a small set of tags in a few sets so that hits and
  // evictions are frequent; a tenth are fully random.
  function automatic logic [ADDR_W-1:0] random_address();
    int s;
    int shift;
    int top_set;
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] set_idx;
    logic [ADDR_W-1:0] offset;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    s = effective_set_bits();
    shift = int'(cfg_block_bits) + s;
    top_set = (1 << s) - 1;
    tag = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    if ($urandom_range(0, 9) < 7 && top_set > 3) set_idx = 64'($urandom_range(0, 3));
    else set_idx = 64'($urandom_range(0, top_set));
    offset = {$urandom, $urandom} & ((64'd1 << cfg_block_bits) - 64'd1);
    return ((shift >= ADDR_W) ? 64'd0 : (tag << shift)) | (set_idx << cfg_block_bits) | offset;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  // Each task below starts and ends right after a falling edge.
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.kind    <= kind;
    in_bus.address <= addr;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pending_results.push_back(predict_access(kind, addr));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves the write channel's valid high; configure() lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_SET_BITS:   cfg_set_bits   = data[SETB_W-1:0];
      REG_BLOCK_BITS: cfg_block_bits = data[BLKB_W-1:0];
      REG_WAYS:       cfg_ways       = data[WAYS_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] set_val,
                           input logic [CFG_DATA_W-1:0] block_val,
                           input logic [CFG_DATA_W-1:0] ways_val);
    write_register(REG_SET_BITS, set_val);
    write_register(REG_BLOCK_BITS, block_val);
    write_register(REG_WAYS, ways_val);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_directed_cases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Reset layout: 16 sets, 16-byte blocks, direct mapped.
    send_request(KIND_LOAD, 64'h0);
    send_request(KIND_LOAD, 64'h0);
    send_request(KIND_STORE, 64'hF);
    send_request(KIND_LOAD, '1);
    send_request(KIND_IGNORE, '1);
    // Modify of a new tag: the first lookup evicts, the second one hits.
    send_request(KIND_MODIFY, 64'h100);
    send_request(KIND_LOAD, 64'h0);
    wait_for_results();

    // Two ways: the invalid way is filled before any valid one is evicted.
    configure(6'd4, 6'd4, 6'd2);
    send_request(KIND_MODIFY, 64'h200);
    send_request(KIND_STORE, 64'h300);
    send_request(KIND_LOAD, 64'h200);
    send_request(KIND_LOAD, 64'h0);
    wait_for_results();

    // Out-of-range index is dropped; the set count saturates, the split is
    // wider than the address so every tag is zero, and zero ways acts as one.
    // Lines stored under the old layout stay in place.
    write_register(REG_UNUSED, 6'h3F);
    configure(6'h3F, 6'h3F, 6'd0);
    send_request(KIND_LOAD, '1);
    send_request(KIND_LOAD, 64'h0);
    send_request(KIND_LOAD, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(KIND_MODIFY, 64'h8000_0000_0000_0000);
    wait_for_results();

    // One set with the full tag, ways above the maximum clamp to the maximum.
    configure(6'd0, 6'd0, 6'd15);
    for (int k = 1; k <= 9; k++) begin
      send_request(KIND_LOAD, (64'(k) << 60) | 64'(k));
    end
    wait_for_results();
    configure(6'(SET_BITS_RST), 6'(BLOCK_BITS_RST), 6'(WAYS_RST));
  endtask

  task automatic test_random_configs();
    int sweep_sets   [6] = '{0, 8, 15, 2, 6, 4};
    int sweep_blocks [6] = '{0, 32, 63, 6, 58, 4};
    int sweep_ways   [6] = '{1, 8, 0, 15, 4, 2};
    int idle_send    [4] = '{0, 75, 0, 9};
    int idle_recv    [4] = '{0, 0, 75, 9};
    for (int c = 0; c < 6; c++) begin
      configure(6'(sweep_sets[c]), 6'(sweep_blocks[c]), 6'(sweep_ways[c]));
      for (int m = 0; m < 4; m++) begin
        send_idle_pct  = idle_send[m];
        recv_stall_pct = idle_recv[m];
        refresh_tag_pool();
        for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_kind(), random_address());
        wait_for_results();
      end
    end
  endtask

  // The receiver holds off while requests keep coming, so the block fills
  // up and must stop taking requests.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    refresh_tag_pool();
    hold_request = PRESSURE_HOLD;
    for (int n = 0; n < 40; n++) send_request(random_kind(), random_address());
    wait_for_results();
  endtask

  initial begin
    out_bus.ready = 1'b0;
    forever begin : ready_drive
      int hold_left;
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want = pending_results.pop_front();
        check_field("was_hit", 32'(out_bus.was_hit), 32'(want.hit));
        check_field("was_miss", 32'(out_bus.was_miss), 32'(want.miss));
        check_field("was_eviction", 32'(out_bus.was_eviction), 32'(want.evict));
        check_field("hit_total", out_bus.hit_total, want.hits);
        check_field("miss_total", out_bus.miss_total, want.misses);
        check_field("eviction_total", out_bus.eviction_total, want.evictions);
      end
    end
  end

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.kind    = KIND_LOAD;
    in_bus.address = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = REG_SET_BITS;
    cfg_bus.data   = '0;
    error_count    = 0;
    hold_request   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i]   = '0;
      shadow_stamp[i] = '0;
    end
    lru_clock      = '0;
    hit_count      = '0;
    miss_count     = '0;
    evict_count    = '0;
    cfg_set_bits   = SET_BITS_RST;
    cfg_block_bits = BLOCK_BITS_RST;
    cfg_ways       = WAYS_RST;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_random_configs();
    test_output_backpressure();

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
